[sv/iptv_pkg.sv]
`timescale 1ns / 1ps

package iptv_pkg;

   // character codes
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharLowA   = 8'h61;
   localparam logic [7:0] CharLowF   = 8'h66;
   localparam logic [7:0] CharUpA    = 8'h41;
   localparam logic [7:0] CharUpF    = 8'h46;
   localparam logic [7:0] CharDot    = 8'h2E;
   localparam logic [7:0] CharColon  = 8'h3A;

   // text length limits
   localparam logic [5:0] LenSat     = 6'd40;
   localparam logic [5:0] V4LenMin   = 6'd7;
   localparam logic [5:0] V4LenMax   = 6'd15;
   localparam logic [5:0] V6LenMin   = 6'd15;
   localparam logic [5:0] V6LenMax   = 6'd39;

   // IPv4 limits
   localparam logic [8:0] FieldMax   = 9'd255;
   localparam logic [8:0] FieldSat   = 9'd256;
   localparam logic [2:0] DotTarget  = 3'd3;
   localparam logic [2:0] DotSat     = 3'd4;

   // IPv6 limits
   localparam logic [2:0] GroupMax   = 3'd4;
   localparam logic [2:0] GroupSat   = 3'd5;
   localparam logic [3:0] ColonTarget = 4'd7;
   localparam logic [3:0] ColonSat   = 4'd8;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_V4   = 2'd1,
      KIND_V6   = 2'd2
   } addr_kind_type;

   // one character moving from the input stage into the checkers
   typedef struct packed {
      logic       fire;
      logic       last_char;
      logic [7:0] char_code;
   } step_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= CharLowA) && (c <= CharLowF)) ||
             ((c >= CharUpA) && (c <= CharUpF));
   endfunction

endpackage

[sv/iptv_v4_check.sv]
`timescale 1ns / 1ps

module iptv_v4_check (
   input  logic              clock,
   input  logic              reset,
   input  iptv_pkg::step_type step,
   output logic              shape_ok
);
   import iptv_pkg::*;

   logic       alive_ff, alive_in;
   logic [8:0] value_ff, value_in;
   logic       has_digit_ff, has_digit_in;
   logic [2:0] dots_ff, dots_in;
   logic [11:0] product;

   always_comb begin
      alive_in     = alive_ff;
      value_in     = value_ff;
      has_digit_in = has_digit_ff;
      dots_in      = dots_ff;
      // value * 10 + digit; digit is the low nibble of an ASCII decimal code
      product = {value_ff, 3'b000} + {2'b00, value_ff, 1'b0} + {8'd0, step.char_code[3:0]};
      if (is_dec(step.char_code)) begin
         // leading zero
         if (has_digit_ff && (value_ff == 9'd0)) begin
            alive_in = 1'b0;
         end
         has_digit_in = 1'b1;
         value_in = (product > {3'd0, FieldSat}) ? FieldSat : product[8:0];
      end else if (step.char_code == CharDot) begin
         if ((value_ff > FieldMax) || !has_digit_ff) begin
            alive_in = 1'b0;
         end
         value_in     = 9'd0;
         has_digit_in = 1'b0;
         if (dots_ff < DotSat) begin
            dots_in = dots_ff + 3'd1;
         end
      end else begin
         alive_in = 1'b0;
      end
      shape_ok = alive_in && (dots_in == DotTarget) && (value_in <= FieldMax) && has_digit_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last_char)) begin
         alive_ff     <= 1'b1;
         value_ff     <= 9'd0;
         has_digit_ff <= 1'b0;
         dots_ff      <= 3'd0;
      end else if (step.fire) begin
         alive_ff     <= alive_in;
         value_ff     <= value_in;
         has_digit_ff <= has_digit_in;
         dots_ff      <= dots_in;
      end
   end

endmodule

[sv/iptv_v6_check.sv]
`timescale 1ns / 1ps

module iptv_v6_check (
   input  logic              clock,
   input  logic              reset,
   input  iptv_pkg::step_type step,
   output logic              shape_ok
);
   import iptv_pkg::*;

   logic       alive_ff, alive_in;
   logic [2:0] group_len_ff, group_len_in;
   logic [3:0] colons_ff, colons_in;

   always_comb begin
      alive_in     = alive_ff;
      group_len_in = group_len_ff;
      colons_in    = colons_ff;
      if (is_hex(step.char_code)) begin
         if (group_len_ff < GroupSat) begin
            group_len_in = group_len_ff + 3'd1;
         end
      end else if (step.char_code == CharColon) begin
         // empty or overlong group
         if ((group_len_ff > GroupMax) || (group_len_ff == 3'd0)) begin
            alive_in = 1'b0;
         end
         group_len_in = 3'd0;
         if (colons_ff < ColonSat) begin
            colons_in = colons_ff + 4'd1;
         end
      end else begin
         alive_in = 1'b0;
      end
      shape_ok = alive_in && (colons_in == ColonTarget) && (group_len_in != 3'd0) &&
                 (group_len_in <= GroupMax);
   end

   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last_char)) begin
         alive_ff     <= 1'b1;
         group_len_ff <= 3'd0;
         colons_ff    <= 4'd0;
      end else if (step.fire) begin
         alive_ff     <= alive_in;
         group_len_ff <= group_len_in;
         colons_ff    <= colons_in;
      end
   end

endmodule

[sv/ip_address_text_validator_top.sv]
`timescale 1ns / 1ps

// IPv4 / IPv6 address text validator.
// The req channel carries one character of the address per transaction,
// with req_last_char set on the final character of the string. Both an
// IPv4 and an IPv6 check run on every character. After the last character
// one rsp transaction carries rsp_addr_kind: 0 neither, 1 IPv4, 2 IPv6.
// Characters other than the last produce no rsp transaction.
// A last character is taken into the input register; when it passes the
// checks it is written to the result register, where rsp_valid rises.
// Throughput: one character per cycle unless stalled; the input and result
// registers are separate, so characters keep flowing while a result waits.
// When rsp_stall is high and a result is held, a further last character
// waits in the input register and req_stall rises; other characters pass.
// Reset (synchronous) clears both checks, the length counter and both
// valid flags. After each last character both checks and the length counter return to reset values.
module ip_address_text_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_addr_kind
);
   import iptv_pkg::*;

   logic          s1_vld_ff;
   logic [7:0]    s1_char_ff;
   logic          s1_last_ff;
   logic          s1_fire;
   logic          req_take;
   logic [5:0]    len_ff, len_in;
   logic          rsp_vld_ff;
   addr_kind_type kind_ff, kind_in;
   logic          v4_shape, v6_shape;
   logic          ok4, ok6;
   step_type      step;

   // a last character needs a free result slot; others never wait
   assign s1_fire   = s1_vld_ff && (!s1_last_ff || !rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   assign step.fire      = s1_fire;
   assign step.last_char = s1_last_ff;
   assign step.char_code = s1_char_ff;

   iptv_v4_check u_v4 (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .shape_ok (v4_shape)
   );

   iptv_v6_check u_v6 (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .shape_ok (v6_shape)
   );

   always_comb begin
      len_in = (len_ff < LenSat) ? (len_ff + 6'd1) : len_ff;
      ok4 = v4_shape && (len_in >= V4LenMin) && (len_in <= V4LenMax);
      ok6 = v6_shape && (len_in >= V6LenMin) && (len_in <= V6LenMax);
      if (ok4) begin
         kind_in = KIND_V4;
      end else if (ok6) begin
         kind_in = KIND_V6;
      end else begin
         kind_in = KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_take) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         len_ff <= 6'd0;
      end else if (s1_fire) begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         kind_ff <= kind_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_addr_kind = kind_ff;

   // never overwrite a result that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stall) |-> !(s1_fire && s1_last_ff))
      else $error("held result overwritten");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenSat)
      else $error("length counter beyond saturation");

   a_len_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (len_ff == 6'd0))
      else $error("length not cleared after end of string");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && s1_last_ff && rsp_vld_ff))
      else $error("input stalled without a held result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> rsp_vld_ff)
      else $error("end of string produced no result");

endmodule
